>>> hdl/mvt_pkg.sv
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform
// holds the beat structs, the mode codes and the lane control struct
// no dependencies
package mvt_pkg;

    localparam int LANES     = 4;
    localparam int FIELD_W   = 32;
    localparam int MODE_W    = 2;
    localparam int SLOT_W    = 2;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_LOAD_ROW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_COL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAT_VEC  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_VEC_MAT  = 2'd3;

    // input beat
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [SLOT_W-1:0]         slot_index;
        logic signed [FIELD_W-1:0] element_0;
        logic signed [FIELD_W-1:0] element_1;
        logic signed [FIELD_W-1:0] element_2;
        logic signed [FIELD_W-1:0] element_3;
    } t_in;

    // output beat
    typedef struct packed {
        logic signed [FIELD_W-1:0] result_0;
        logic signed [FIELD_W-1:0] result_1;
        logic signed [FIELD_W-1:0] result_2;
        logic signed [FIELD_W-1:0] result_3;
        logic                      saturated;
    } t_out;

    // per-stage load enables shared by all lanes
    typedef struct packed {
        logic prod_en;
        logic pair_en;
        logic sum_en;
        logic res_en;
    } t_lane_ctl;

endpackage

>>> hdl/mvt_lane.sv
// mvt_lane: one dot-product lane, four multipliers, adder tree, shift and saturate
// stages: products, pair sums, full sum, truncated and clipped result
// depends on mvt_pkg
module mvt_lane
    import mvt_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  t_lane_ctl                    i_ctl,
    input  logic signed [DATA_WIDTH-1:0] i_mat [LANES],
    input  logic signed [DATA_WIDTH-1:0] i_vec [LANES],
    output logic signed [FIELD_W-1:0]    o_result,
    output logic                         o_sat
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] MAX_VAL =
        {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_VAL =
        {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    logic signed [PW-1:0]         r_prod [LANES];
    logic signed [PW:0]           r_pair0;
    logic signed [PW:0]           r_pair1;
    logic signed [SW-1:0]         r_sum;
    logic signed [SW-1:0]         w_shifted;
    logic signed [DATA_WIDTH-1:0] w_clip;
    logic                         w_sat;

    // products, one multiplier per element
    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            for (int j = 0; j < LANES; j++) begin
                r_prod[j] <= i_mat[j] * i_vec[j];
            end
        end
    end

    // pair sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.pair_en) begin
            r_pair0 <= (PW+1)'(r_prod[0]) + (PW+1)'(r_prod[1]);
            r_pair1 <= (PW+1)'(r_prod[2]) + (PW+1)'(r_prod[3]);
        end
    end

    // exact full sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sum <= SW'(r_pair0) + SW'(r_pair1);
        end
    end

    // arithmetic shift truncates toward minus infinity, then clip
    always_comb begin
        w_shifted = r_sum >>> FRAC_BITS;
        w_sat     = 1'b0;
        if (w_shifted > MAX_VAL) begin
            w_clip = MAX_VAL[DATA_WIDTH-1:0];
            w_sat  = 1'b1;
        end else if (w_shifted < MIN_VAL) begin
            w_clip = MIN_VAL[DATA_WIDTH-1:0];
            w_sat  = 1'b1;
        end else begin
            w_clip = w_shifted[DATA_WIDTH-1:0];
        end
    end

    // lane result, sign-extended to the field width
    always_ff @(posedge i_clk) begin
        if (i_ctl.res_en) begin
            o_result <= FIELD_W'(w_clip);
            o_sat    <= w_sat;
        end
    end

endmodule

>>> hdl/mvt_merge.sv
// mvt_merge: output register that gathers the four lane results
// folds the lane clip flags into one saturated flag
// depends on mvt_pkg
module mvt_merge
    import mvt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [FIELD_W-1:0] i_result [LANES],
    input  logic [LANES-1:0]          i_sat,
    output t_out                      o_data
);

    t_out n_data;

    // combine lanes
    always_comb begin
        n_data.result_0  = i_result[0];
        n_data.result_1  = i_result[1];
        n_data.result_2  = i_result[2];
        n_data.result_3  = i_result[3];
        n_data.saturated = |i_sat;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= n_data;
        end
    end

endmodule

>>> hdl/matrix_vector_transform.sv
// matrix_vector_transform: 4x4 signed fixed-point matrix with vector transform
// top level: matrix registers, operand capture, four mvt_lane copies, mvt_merge
// depends on mvt_pkg, mvt_lane, mvt_merge
//
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) carries one item per beat.
//   a load-row or load-column beat writes four matrix entries and returns nothing;
//   a transform beat returns one output beat (o_out_valid / i_out_ready / o_out_data)
//   holding M*v or v*M, each element truncated by FRAC_BITS and clipped to
//   DATA_WIDTH bits, with a flag set when any element was clipped.
//   a transform accepted on the input passes operand capture, multiply, pair add,
//   full add, clip and the output register before it is shown on the output.
//   throughput: one beat per cycle while the output is not stalled, set by the four
//   lanes of four multipliers each working in parallel on every element of a beat.
//   a transform right after a load sees the new matrix.
//   a stall on the output holds the result; the stages behind it keep filling
//   empty slots and o_in_ready drops only once every stage holds a beat.
//   reset clears the matrix to zero and empties the pipeline.
module matrix_vector_transform
    import mvt_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int STAGES = 6;

    logic signed [DATA_WIDTH-1:0] r_mat [LANES][LANES];
    logic signed [DATA_WIDTH-1:0] r_op_mat [LANES][LANES];
    logic signed [DATA_WIDTH-1:0] r_op_vec [LANES];
    logic signed [DATA_WIDTH-1:0] w_elem [LANES];
    logic [STAGES-1:0]            r_valid;
    logic [STAGES-1:0]            n_valid;
    logic [STAGES-1:0]            w_rdy;
    logic                         w_accept;
    logic                         w_xform;
    t_lane_ctl                    w_ctl;
    logic signed [FIELD_W-1:0]    w_lane_res [LANES];
    logic [LANES-1:0]             w_lane_sat;

    assign w_elem[0] = i_in_data.element_0[DATA_WIDTH-1:0];
    assign w_elem[1] = i_in_data.element_1[DATA_WIDTH-1:0];
    assign w_elem[2] = i_in_data.element_2[DATA_WIDTH-1:0];
    assign w_elem[3] = i_in_data.element_3[DATA_WIDTH-1:0];

    // stage ready chain, a stage moves when empty or when the next one moves
    always_comb begin
        w_rdy[STAGES-1] = !r_valid[STAGES-1] || i_out_ready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            w_rdy[s] = !r_valid[s] || w_rdy[s+1];
        end
    end

    // no beat is taken while reset is held
    assign o_in_ready  = w_rdy[0] && i_rst_n;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_xform     = (i_in_data.mode == MODE_MAT_VEC) || (i_in_data.mode == MODE_VEC_MAT);
    assign o_out_valid = r_valid[STAGES-1];

    // valid bits
    always_comb begin
        n_valid[0] = w_rdy[0] ? (w_accept && w_xform) : r_valid[0];
        for (int s = 1; s < STAGES; s++) begin
            n_valid[s] = w_rdy[s] ? r_valid[s-1] : r_valid[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // matrix store, one row or one column written per load beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < LANES; r++) begin
                for (int c = 0; c < LANES; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
        end else if (w_accept) begin
            for (int r = 0; r < LANES; r++) begin
                for (int c = 0; c < LANES; c++) begin
                    if (i_in_data.mode == MODE_LOAD_ROW &&
                        i_in_data.slot_index == SLOT_W'(r)) begin
                        r_mat[r][c] <= w_elem[c];
                    end else if (i_in_data.mode == MODE_LOAD_COL &&
                                 i_in_data.slot_index == SLOT_W'(c)) begin
                        r_mat[r][c] <= w_elem[r];
                    end
                end
            end
        end
    end

    // operand capture, each lane gets a row or a column
    always_ff @(posedge i_clk) begin
        if (w_accept && w_xform) begin
            for (int i = 0; i < LANES; i++) begin
                r_op_vec[i] <= w_elem[i];
                for (int j = 0; j < LANES; j++) begin
                    r_op_mat[i][j] <= (i_in_data.mode == MODE_VEC_MAT) ? r_mat[j][i]
                                                                        : r_mat[i][j];
                end
            end
        end
    end

    // stage load enables
    assign w_ctl.prod_en = w_rdy[1] && r_valid[0];
    assign w_ctl.pair_en = w_rdy[2] && r_valid[1];
    assign w_ctl.sum_en  = w_rdy[3] && r_valid[2];
    assign w_ctl.res_en  = w_rdy[4] && r_valid[3];

    // dot-product lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mvt_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_mat    (r_op_mat[g]),
            .i_vec    (r_op_vec),
            .o_result (w_lane_res[g]),
            .o_sat    (w_lane_sat[g])
        );
    end

    // merge into the output register
    mvt_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (w_rdy[5] && r_valid[4]),
        .i_result (w_lane_res),
        .i_sat    (w_lane_sat),
        .o_data   (o_out_data)
    );

endmodule

>>> hdl/mvt_checker.sv
// mvt_checker: port-level checks for matrix_vector_transform
// bound to the top level below; depends on mvt_pkg
module mvt_checker
    import mvt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    localparam logic signed [FIELD_W-1:0] MAX_RES = FIELD_W'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
    localparam logic signed [FIELD_W-1:0] MIN_RES = -MAX_RES - 1;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] DEPTH = 4'd6;

    logic [CNT_W-1:0] r_pending;
    logic [CNT_W-1:0] n_pending;
    logic             w_in_xform;
    logic             w_out_beat;

    assign w_in_xform = i_in_valid && o_in_ready &&
                        (i_in_data.mode == MODE_MAT_VEC || i_in_data.mode == MODE_VEC_MAT);
    assign w_out_beat = o_out_valid && i_out_ready;

    // transforms accepted but not yet delivered
    always_comb begin
        n_pending = r_pending + CNT_W'(w_in_xform) - CNT_W'(w_out_beat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // a stalled output beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // the clip flag means some element sits at a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.saturated |->
            o_out_data.result_0 == MAX_RES || o_out_data.result_0 == MIN_RES ||
            o_out_data.result_1 == MAX_RES || o_out_data.result_1 == MIN_RES ||
            o_out_data.result_2 == MAX_RES || o_out_data.result_2 == MIN_RES ||
            o_out_data.result_3 == MAX_RES || o_out_data.result_3 == MIN_RES)
        else $error("saturated flag without a clipped element");

    // no result without a transform behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != '0)
        else $error("result beat with no pending transform");

    // never more in flight than the pipeline holds
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= DEPTH)
        else $error("more transforms in flight than pipeline stages");

endmodule

bind matrix_vector_transform mvt_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_mvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
